/* rtl/ipid_pkg.sv */
package ipid_pkg;

  // fixed field widths
  localparam int GAIN_W         = 24;
  localparam int RKI_W          = 25;
  localparam int BAND_W         = 16;
  localparam int STEPS_W        = 16;
  localparam int ACC_W          = 48;
  localparam int BAND_FRAC_BITS = 12;
  localparam int MUL_A_W        = 26;
  localparam int CFG_IDX_W      = 3;
  localparam int DIV_CNT_W      = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GAIN_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_FRAC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS = 3'd5;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_BAND = 2'd0,
    MUL_KP   = 2'd1,
    MUL_KD   = 2'd2,
    MUL_KI   = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     cfg_we;
    logic     capture;
    logic     div_init;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     band_eval;
    logic     sum_add;
    logic     sum_add_cond;
    logic     write_back;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

/* rtl/ipid_datapath.sv */
module ipid_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int CFG_DATA_W  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ipid_pkg::dp_cmd_t                   cmd_i,
  output ipid_pkg::dp_sts_t                   sts_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]       feedback_i,
  output logic signed [ipid_pkg::ACC_W-1:0]   control_value_o,
  output logic                                saturated_o
);

  localparam int EW   = SAMPLE_BITS + 1;
  localparam int D1W  = SAMPLE_BITS + 2;
  localparam int D2W  = SAMPLE_BITS + 3;
  localparam int MBW  = SAMPLE_BITS + 3;
  localparam int PW   = ipid_pkg::MUL_A_W + MBW;
  localparam int CW   = SAMPLE_BITS + 16;
  localparam int SW   = ((ipid_pkg::ACC_W > PW + 2) ? ipid_pkg::ACC_W : PW + 2) + 2;
  localparam int AW   = ipid_pkg::ACC_W;
  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};

  // configuration registers
  logic signed [SAMPLE_BITS-1:0]       sp_q;
  logic [ipid_pkg::GAIN_W-1:0]         kp_q, ki_q, kd_q;
  logic [ipid_pkg::BAND_W-1:0]         band_q;
  logic [ipid_pkg::STEPS_W-1:0]        steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= '0;
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      band_q  <= '0;
      steps_q <= ipid_pkg::STEPS_W'(1);
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        ipid_pkg::REG_SETPOINT:   sp_q    <= cfg_data_i[SAMPLE_BITS-1:0];
        ipid_pkg::REG_KP_GAIN:    kp_q    <= cfg_data_i[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_KI_GAIN:    ki_q    <= cfg_data_i[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_KD_GAIN:    kd_q    <= cfg_data_i[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_BAND_FRAC:  band_q  <= cfg_data_i[ipid_pkg::BAND_W-1:0];
        ipid_pkg::REG_RAMP_STEPS: steps_q <= cfg_data_i[ipid_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divider for the ramp step, one quotient bit a cycle
  logic [ipid_pkg::STEPS_W-1:0]   divisor;
  logic [ipid_pkg::STEPS_W-1:0]   rem_q;
  logic [ipid_pkg::GAIN_W-1:0]    quo_q;
  logic [ipid_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [ipid_pkg::STEPS_W:0]     shifted;
  logic                           fits;

  assign divisor = (steps_q == '0) ? ipid_pkg::STEPS_W'(1) : steps_q;
  assign shifted = {rem_q, quo_q[ipid_pkg::GAIN_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign sts_o.div_last = (div_cnt_q == ipid_pkg::DIV_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      rem_q     <= '0;
      quo_q     <= ki_q;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= fits ? ipid_pkg::STEPS_W'(shifted - {1'b0, divisor})
                        : shifted[ipid_pkg::STEPS_W-1:0];
      quo_q     <= {quo_q[ipid_pkg::GAIN_W-2:0], fits};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // error history and ramped gain
  logic signed [EW-1:0]          e_q, e1_q, e2_q;
  logic [ipid_pkg::RKI_W-1:0]    rki_q;
  logic signed [D1W-1:0]         d1;
  logic signed [D2W-1:0]         d2;
  logic [EW-1:0]                 abs_e;
  logic [SAMPLE_BITS-1:0]        abs_sp;

  assign d1     = D1W'(e_q) - D1W'(e1_q);
  assign d2     = D2W'(e_q) - (D2W'(e1_q) <<< 1) + D2W'(e2_q);
  assign abs_e  = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
  assign abs_sp = sp_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sp_q) : SAMPLE_BITS'(sp_q);

  // shared multiplier
  logic signed [ipid_pkg::MUL_A_W-1:0] mul_a;
  logic signed [MBW-1:0]               mul_b;
  logic signed [PW-1:0]                prod_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      ipid_pkg::MUL_BAND: begin
        mul_a = {{(ipid_pkg::MUL_A_W-ipid_pkg::BAND_W){1'b0}}, band_q};
        mul_b = {{(MBW-SAMPLE_BITS){1'b0}}, abs_sp};
      end
      ipid_pkg::MUL_KP: begin
        mul_a = {{(ipid_pkg::MUL_A_W-ipid_pkg::GAIN_W){1'b0}}, kp_q};
        mul_b = {{(MBW-D1W){d1[D1W-1]}}, d1};
      end
      ipid_pkg::MUL_KD: begin
        mul_a = {{(ipid_pkg::MUL_A_W-ipid_pkg::GAIN_W){1'b0}}, kd_q};
        mul_b = d2;
      end
      ipid_pkg::MUL_KI: begin
        mul_a = {{(ipid_pkg::MUL_A_W-ipid_pkg::RKI_W){1'b0}}, rki_q};
        mul_b = {{(MBW-EW){e_q[EW-1]}}, e_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // band test against the registered |setpoint| * band_fraction
  logic [CW-1:0] band_lhs;
  logic          inband;
  logic          inband_q;

  assign band_lhs = CW'({abs_e, {ipid_pkg::BAND_FRAC_BITS{1'b0}}});
  assign inband   = band_lhs <= prod_q[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rki_q <= '0;
    end else if (cmd_i.band_eval && inband && (rki_q < {1'b0, ki_q})) begin
      rki_q <= rki_q + ipid_pkg::RKI_W'(quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.band_eval) begin
      inband_q <= inband;
    end
  end

  // increment accumulation and saturation
  logic signed [SW-1:0] sum_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] acc_d;
  logic                 sat_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.band_eval) begin
      sum_q <= SW'(acc_q);
    end else if (cmd_i.sum_add || (cmd_i.sum_add_cond && inband_q)) begin
      sum_q <= sum_q + SW'(prod_q);
    end
  end

  always_comb begin
    if (sum_q > SUM_MAX) begin
      acc_d = SUM_MAX[AW-1:0];
      sat_d = 1'b1;
    end else if (sum_q < SUM_MIN) begin
      acc_d = SUM_MIN[AW-1:0];
      sat_d = 1'b1;
    end else begin
      acc_d = sum_q[AW-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      e1_q  <= '0;
      e2_q  <= '0;
    end else if (cmd_i.write_back) begin
      acc_q <= acc_d;
      e1_q  <= e_q;
      e2_q  <= e1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      e_q <= EW'(feedback_i) - EW'(sp_q);
    end
  end

  logic signed [AW-1:0] out_value_q;
  logic                 out_sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_back) begin
      out_value_q <= acc_d;
      out_sat_q   <= sat_d;
    end
  end

  assign control_value_o = out_value_q;
  assign saturated_o     = out_sat_q;

endmodule

/* rtl/ipid_ctrl.sv */
module ipid_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ipid_pkg::dp_cmd_t              cmd_o,
  input  ipid_pkg::dp_sts_t              sts_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DLOAD = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_BAND  = 9'b000001000,
    S_KP    = 9'b000010000,
    S_KD    = 9'b000100000,
    S_KI    = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_WB    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   div_start;

  // registers only change between ticks
  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_DLOAD) || (state_q == S_DIV);
  assign div_start   = cfg_valid_i && cfg_ready_o &&
                       ((cfg_index_i == ipid_pkg::REG_KI_GAIN) ||
                        (cfg_index_i == ipid_pkg::REG_RAMP_STEPS));
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.mul_sel      = ipid_pkg::MUL_BAND;
    cmd_o.cfg_we       = cfg_valid_i && cfg_ready_o;
    out_valid_d        = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (div_start) begin
          state_d = S_DLOAD;
        end else if (in_valid_i && in_ready_o) begin
          cmd_o.capture = 1'b1;
          state_d       = S_BAND;
        end
      end
      S_DLOAD: begin
        cmd_o.div_init = 1'b1;
        state_d        = div_start ? S_DLOAD : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_start) begin
          state_d = S_DLOAD;
        end else if (sts_i.div_last) begin
          state_d = S_IDLE;
        end
      end
      S_BAND: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ipid_pkg::MUL_BAND;
        state_d       = S_KP;
      end
      S_KP: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = ipid_pkg::MUL_KP;
        cmd_o.band_eval = 1'b1;
        state_d         = S_KD;
      end
      S_KD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ipid_pkg::MUL_KD;
        cmd_o.sum_add = 1'b1;
        state_d       = S_KI;
      end
      S_KI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ipid_pkg::MUL_KI;
        cmd_o.sum_add = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.sum_add_cond = 1'b1;
        state_d            = S_WB;
      end
      S_WB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.write_back = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/incremental_pid_dead_zone_ramped_ki.sv */
// channel   direction  handshake                 payload
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o   feedback_i
// out       out        out_valid_o / out_ready_i control_value_o, saturated_o
//
// one feedback beat runs four passes through the shared multiplier (band limit,
// kp, kd, ki), then accumulate and write-back, before the next accept
// a write to ki_gain or ramp_steps starts a bit-serial divide of the ramp step;
// in_ready_o stays low until it finishes
// cfg_ready_o is low while a tick is computed; out of reset the block is idle
// a stalled out beat holds the next item at write-back; input accept stops until it leaves
module incremental_pid_dead_zone_ramped_ki #(
  parameter int SAMPLE_BITS = 16,
  // data port is wide enough for the setpoint and the 24-bit gains
  localparam int CfgDataW = (SAMPLE_BITS > ipid_pkg::GAIN_W) ? SAMPLE_BITS
                                                             : ipid_pkg::GAIN_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]                 cfg_data_i,
  // feedback samples
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       feedback_i,
  // control results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ipid_pkg::ACC_W-1:0]   control_value_o,
  output logic                                saturated_o
);

  ipid_pkg::dp_cmd_t cmd;
  ipid_pkg::dp_sts_t sts;

  // sequencer: accept, multiplier schedule, divider steps, out beat
  ipid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // config registers, error history, ramped gain, accumulator
  ipid_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CFG_DATA_W  (CfgDataW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .feedback_i      (feedback_i),
    .control_value_o (control_value_o),
    .saturated_o     (saturated_o)
  );

endmodule

/* test/ctrl_tick_checker.sv */
module ctrl_tick_checker #(
  parameter int SampleW = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ipid_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [SampleW-1:0]            feedback_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [ipid_pkg::ACC_W-1:0]    control_value_i,
  input  logic                                 saturated_i,
  output int                                   mismatches_o,
  output int                                   pending_o,
  output int                                   ticks_o,
  output int                                   clamps_o,
  output int                                   in_band_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint AccMax  = (longint'(1) <<< (ipid_pkg::ACC_W - 1)) - 1;
  localparam longint AccMin  = -AccMax - 1;
  localparam longint RkiMask = (longint'(1) <<< ipid_pkg::RKI_W) - 1;

  typedef struct packed {
    logic signed [ipid_pkg::ACC_W-1:0] value;
    logic                              clamped;
  } ctrl_beat_t;

  ctrl_beat_t ctrl_due[$];

  // register copies
  logic signed [SampleW-1:0]       setpoint_q;
  logic [ipid_pkg::GAIN_W-1:0]     kp_q, ki_q, kd_q;
  logic [ipid_pkg::BAND_W-1:0]     band_q;
  logic [ipid_pkg::STEPS_W-1:0]    steps_q;

  // loop state
  logic signed [SampleW:0]           err_d1, err_d2;
  logic [ipid_pkg::RKI_W-1:0]        ramped_ki_q;
  logic signed [ipid_pkg::ACC_W-1:0] acc_q;

  int mismatches, ticks, clamps, in_band;

  // one control tick: error, band test, ramp, increment, clamp
  function automatic ctrl_beat_t advance_pid(input logic signed [SampleW-1:0] fb);
    longint     err, err1, err2, mag_err, mag_sp, inc, total, divisor, rki;
    ctrl_beat_t beat;
    err     = longint'(fb) - longint'(setpoint_q);
    err1    = longint'(err_d1);
    err2    = longint'(err_d2);
    mag_err = (err < 0) ? -err : err;
    mag_sp  = (setpoint_q < 0) ? -longint'(setpoint_q) : longint'(setpoint_q);
    inc = longint'(kp_q) * (err - err1) + longint'(kd_q) * (err - 2 * err1 + err2);
    if ((mag_err <<< ipid_pkg::BAND_FRAC_BITS) <= mag_sp * longint'(band_q)) begin
      divisor = (steps_q == '0) ? longint'(1) : longint'(steps_q);
      rki     = longint'(ramped_ki_q);
      if (rki < longint'(ki_q)) begin
        rki = (rki + longint'(ki_q) / divisor) & RkiMask;
      end
      ramped_ki_q = rki[ipid_pkg::RKI_W-1:0];
      inc += rki * err;
      in_band++;
    end
    total        = longint'(acc_q) + inc;
    beat.clamped = 1'b0;
    if (total > AccMax) begin
      total        = AccMax;
      beat.clamped = 1'b1;
    end else if (total < AccMin) begin
      total        = AccMin;
      beat.clamped = 1'b1;
    end
    acc_q      = total[ipid_pkg::ACC_W-1:0];
    err_d2     = err_d1;
    err_d1     = err[SampleW:0];
    beat.value = acc_q;
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ctrl_beat_t want;
    if (!rst_ni) begin
      setpoint_q  = '0;
      kp_q        = '0;
      ki_q        = '0;
      kd_q        = '0;
      band_q      = '0;
      steps_q     = ipid_pkg::STEPS_W'(1);
      err_d1      = '0;
      err_d2      = '0;
      ramped_ki_q = '0;
      acc_q       = '0;
      ctrl_due.delete();
      mismatches  = 0;
      ticks       = 0;
      clamps      = 0;
      in_band     = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      ticks_o      <= 0;
      clamps_o     <= 0;
      in_band_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ipid_pkg::REG_SETPOINT:   setpoint_q = cfg_data_i[SampleW-1:0];
          ipid_pkg::REG_KP_GAIN:    kp_q       = cfg_data_i;
          ipid_pkg::REG_KI_GAIN:    ki_q       = cfg_data_i;
          ipid_pkg::REG_KD_GAIN:    kd_q       = cfg_data_i;
          ipid_pkg::REG_BAND_FRAC:  band_q     = cfg_data_i[ipid_pkg::BAND_W-1:0];
          ipid_pkg::REG_RAMP_STEPS: steps_q    = cfg_data_i[ipid_pkg::STEPS_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing, a beat never leaves in its own accept cycle
      if (out_valid_i && out_ready_i) begin
        if (ctrl_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected control beat, expected none, actual %0d sat %0b",
                   $time, control_value_i, saturated_i);
        end else begin
          want = ctrl_due.pop_front();
          ticks++;
          if (want.clamped) clamps++;
          if (control_value_i !== want.value) begin
            mismatches++;
            $display("%0t ns: control_value expected %0d actual %0d",
                     $time, want.value, control_value_i);
          end
          if (saturated_i !== want.clamped) begin
            mismatches++;
            $display("%0t ns: saturated expected %0b actual %0b",
                     $time, want.clamped, saturated_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        ctrl_due.push_back(advance_pid(feedback_i));
      end
      mismatches_o <= mismatches;
      pending_o    <= ctrl_due.size();
      ticks_o      <= ticks;
      clamps_o     <= clamps;
      in_band_o    <= in_band;
    end
  end

endmodule

/* test/incremental_pid_dead_zone_ramped_ki_tb.sv */
module incremental_pid_dead_zone_ramped_ki_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW      = 16;
  localparam int HoldCycles   = 300;  // long receiver hold-off
  localparam int DrainLimit   = 5000;
  localparam int SettleCycles = 12;   // a bit over one tick of latency
  localparam int PhaseItems   = 100;

  // indexes past the register file, writes must change nothing
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] RegSpareA = 3'd6;
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] RegSpareB = 3'd7;

  // pacing modes
  localparam int PaceFree   = 0;
  localparam int PaceGaps   = 1;
  localparam int PaceStalls = 2;
  localparam int PaceBoth   = 3;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [ipid_pkg::GAIN_W-1:0]       cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [SampleW-1:0]         feedback;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [ipid_pkg::ACC_W-1:0] control_value;
  logic                              saturated;

  int mismatches, pending, ticks, clamps, in_band;

  // pacing knobs
  int   idle_pct;
  int   stall_pct;
  logic hold_req;
  logic hold_ack;
  int   hold_left;

  int                        cfg_writes;
  logic signed [SampleW-1:0] sp_now;
  logic signed [SampleW-1:0] last_fb;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  incremental_pid_dead_zone_ramped_ki #(
    .SAMPLE_BITS(SampleW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .feedback_i      (feedback),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .control_value_o (control_value),
    .saturated_o     (saturated)
  );

  ctrl_tick_checker #(
    .SampleW(SampleW)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .feedback_i      (feedback),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .control_value_i (control_value),
    .saturated_i     (saturated),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .ticks_o         (ticks),
    .clamps_o        (clamps),
    .in_band_o       (in_band)
  );

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_ack  <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one register write, then a quiet cycle so valid never drops and rises in one step
  task automatic write_reg(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ipid_pkg::GAIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // full register set, upper setpoint bits are junk the block has to drop
  task automatic load_gains(input logic signed [SampleW-1:0] sp,
                            input logic [ipid_pkg::GAIN_W-1:0] kp, ki, kd,
                            input logic [ipid_pkg::BAND_W-1:0] band,
                            input logic [ipid_pkg::STEPS_W-1:0] steps);
    write_reg(ipid_pkg::REG_SETPOINT, {8'($urandom), sp});
    write_reg(ipid_pkg::REG_KP_GAIN, kp);
    write_reg(ipid_pkg::REG_KI_GAIN, ki);
    write_reg(ipid_pkg::REG_KD_GAIN, kd);
    write_reg(ipid_pkg::REG_BAND_FRAC, {8'($urandom), band});
    write_reg(ipid_pkg::REG_RAMP_STEPS, {8'($urandom), steps});
    sp_now = sp;
  endtask

  // feedback beat; gaps drawn per cycle, valid held across back-to-back beats
  task automatic send_tick(input logic signed [SampleW-1:0] fb);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    feedback <= fb;
    last_fb   = fb;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // all results back, then let the block settle before touching registers
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DrainLimit);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      PaceGaps: begin
        idle_pct   = 56;
        stall_pct <= 0;
      end
      PaceStalls: begin
        idle_pct   = 0;
        stall_pct <= 56;
      end
      PaceBoth: begin
        idle_pct   = 38;
        stall_pct <= 38;
      end
      default: begin
        idle_pct   = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  function automatic logic [ipid_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return ipid_pkg::GAIN_W'($urandom);
      default: return ipid_pkg::GAIN_W'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 16'h1000;  // band of one times setpoint
      3:       return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] pick_setpoint();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'sh8000;
      2:       return 16'sh7FFF;
      3:       return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // mix: anything, near the setpoint (within 32), extremes, repeat the last sample
  function automatic logic signed [SampleW-1:0] pick_feedback();
    int kind;
    int v;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      return 16'($urandom);
    end else if (kind < 70) begin
      v = int'(sp_now) + int'($urandom_range(0, 64)) - 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end else if (kind < 85) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    return last_fb;
  endfunction

  task automatic random_phase(input int mode, input bit with_hold);
    set_pace(mode);
    load_gains(pick_setpoint(), pick_gain(), pick_gain(), pick_gain(), pick_half(),
               pick_half());
    if (with_hold) begin
      // receiver goes quiet while the sender keeps offering beats
      hold_req <= ~hold_req;
    end
    repeat (PhaseItems) send_tick(pick_feedback());
    drain();
  endtask

  initial begin : stimulus
    int v;
    rst_ni     <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= ipid_pkg::REG_SETPOINT;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    feedback   <= '0;
    hold_req   <= 1'b0;
    stall_pct  <= 0;
    idle_pct    = 0;
    cfg_writes  = 0;
    sp_now      = '0;
    last_fb     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small ki, three steps: ramp 2, 4, 6 then overshoot to 8; band edge at |e| = 100
    set_pace(PaceFree);
    load_gains(16'sd100, 24'h010000, 24'h000007, 24'h004000, 16'h1000, 16'd3);
    send_tick(16'sd100);
    send_tick(16'sd200);   // exactly on the band edge, still in
    send_tick(16'sd201);   // just outside
    send_tick(16'sd0);
    send_tick(-16'sd1);
    send_tick(16'sd150);
    send_tick(16'sd150);   // ramp done, gain holds
    drain();

    // zero band with zero setpoint: in band only on zero error; zero steps act as one
    load_gains(16'sd0, 24'h020000, 24'h000040, 24'h000100, 16'h0000, 16'd0);
    send_tick(16'sd0);
    send_tick(16'sd5);
    send_tick(16'sd0);
    drain();

    // writes past the register file
    write_reg(RegSpareA, ipid_pkg::GAIN_W'($urandom));
    write_reg(RegSpareB, ipid_pkg::GAIN_W'($urandom));

    // ki lowered under the ramped gain, step truncated to zero, full-scale errors
    load_gains(16'sh8000, 24'hFFFFFF, 24'h000010, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    send_tick(16'sh7FFF);
    send_tick(16'sd0);
    send_tick(-16'sd1);
    drain();

    random_phase(PaceFree, 1'b0);
    random_phase(PaceGaps, 1'b0);
    random_phase(PaceStalls, 1'b0);
    random_phase(PaceBoth, 1'b0);

    // windup: full ki in band with a steady large error, up into the clamp
    set_pace(PaceGaps);
    load_gains(16'sh8000, 24'h000000, 24'hFFFFFF, 24'h000000, 16'hFFFF, 16'd1);
    repeat (150) send_tick(16'($urandom_range(16384, 32767)));
    drain();
    // and back down through zero into the negative clamp
    set_pace(PaceStalls);
    load_gains(16'sh7FFF, 24'h000100, 24'hFFFFFF, 24'h000100, 16'hFFFF, 16'd1);
    repeat (200) begin
      v = -32768 + int'($urandom_range(0, 16384));
      send_tick(16'(v));
    end
    drain();

    random_phase(PaceFree, 1'b1);
    random_phase(PaceBoth, 1'b0);
    random_phase(PaceGaps, 1'b0);
    random_phase(PaceStalls, 1'b0);

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d control ticks and %0d register writes, %0d ticks clamped,",
             ticks, cfg_writes, clamps);
    $display("%0d ticks in the integral band, under free, gapped, stalled and held pacing",
             in_band);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #(2_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/ipid_pkg.sv
rtl/ipid_datapath.sv
rtl/ipid_ctrl.sv
rtl/incremental_pid_dead_zone_ramped_ki.sv
test/ctrl_tick_checker.sv
test/incremental_pid_dead_zone_ramped_ki_tb.sv
